[rtl/ssc_pkg.sv]
// shared types and constants for the stack sequence checker
// no dependencies; imported by ssc_seq and stack_sequence_checker_core
package ssc_pkg;

    // stack and target buffer depth
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;
    localparam int VERDICT_W   = 2;

    // verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NO       = 2'd0,
        VERDICT_YES      = 2'd1,
        VERDICT_TOO_LONG = 2'd2
    } verdict_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_EMIT
    } state_t;

    // memory requests from the sequencer
    typedef struct packed {
        logic              stack_we;
        logic [ADDR_W-1:0] stack_waddr;
        logic [SYM_W-1:0]  stack_wdata;
        logic              stack_re;
        logic [ADDR_W-1:0] stack_raddr;
        logic              target_we;
        logic [ADDR_W-1:0] target_waddr;
        logic [SYM_W-1:0]  target_wdata;
        logic              target_re;
        logic [ADDR_W-1:0] target_raddr;
    } mem_req_t;

    // verdict handed from the sequencer to the output register
    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } emit_t;

endpackage

[rtl/stack_sequence_checker_core.sv]
// top level of the stack sequence checker: rams, sequencer, output register
// depends on ssc_pkg, ssc_ram and ssc_seq
//
//  channel  signals                                          direction
//  input    in_valid in_ready source_char target_char last_char  in
//  output   out_valid out_ready verdict                        out
//
// an item is pushed, then compared against the next unmatched target, one compare
// at a time as each ram has a single read port; the stack pops while the top
// matches, until a mismatch, an empty stack or the last buffered target; an item
// past the depth limit is not pushed, and a last item then hands over its verdict
// rst_n clears all counters and the sequencer; ram contents are not cleared.
// a waiting verdict does not block input until the next verdict is ready.
module stack_sequence_checker_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ssc_pkg::SYM_W-1:0]  source_char,
    input  logic [ssc_pkg::SYM_W-1:0]  target_char,
    input  logic                       last_char,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ssc_pkg::VERDICT_W-1:0] verdict
);

    import ssc_pkg::*;

    mem_req_t              mem_req;
    emit_t                 emit;
    logic                  emit_ready;
    logic [SYM_W-1:0]      stack_rdata;
    logic [SYM_W-1:0]      target_rdata;
    logic                  out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0]  verdict_reg, verdict_next;

    // stack memory
    ssc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_req.stack_we),
        .waddr (mem_req.stack_waddr),
        .wdata (mem_req.stack_wdata),
        .re    (mem_req.stack_re),
        .raddr (mem_req.stack_raddr),
        .rdata (stack_rdata)
    );

    // target buffer memory
    ssc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_target_ram (
        .clk   (clk),
        .we    (mem_req.target_we),
        .waddr (mem_req.target_waddr),
        .wdata (mem_req.target_wdata),
        .re    (mem_req.target_re),
        .raddr (mem_req.target_raddr),
        .rdata (target_rdata)
    );

    // sequencer
    ssc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_char  (source_char),
        .target_char  (target_char),
        .last_char    (last_char),
        .stack_rdata  (stack_rdata),
        .target_rdata (target_rdata),
        .mem_req      (mem_req),
        .emit         (emit),
        .emit_ready   (emit_ready)
    );

    // output register
    assign emit_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        priority if (emit.valid && emit_ready)
        begin
            out_valid_next = 1'b1;
            verdict_next   = emit.verdict;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // a push writes both memories together
    a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.stack_we == mem_req.target_we)
    else $error("stack and target writes out of step");

    // a push never coincides with a stack read
    a_no_stack_rw: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.stack_we |-> !mem_req.stack_re)
    else $error("stack read during push");

    // no input accepted while the sequencer works on memory compares
    a_no_accept_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.stack_re |-> !in_ready)
    else $error("input accepted during pop loop");

    // a delivered verdict is a defined code
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_NO || verdict == VERDICT_YES ||
                       verdict == VERDICT_TOO_LONG))
    else $error("undefined verdict code");

endmodule

[rtl/ssc_ram.sv]
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ssc_seq.sv]
// sequencer: counters, push on accept, pop-while-match loop over the rams, verdict
// depends on ssc_pkg; drives the stack and target rams through mem_req_t
module ssc_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ssc_pkg::SYM_W-1:0] source_char,
    input  logic [ssc_pkg::SYM_W-1:0] target_char,
    input  logic                     last_char,
    input  logic [ssc_pkg::SYM_W-1:0] stack_rdata,
    input  logic [ssc_pkg::SYM_W-1:0] target_rdata,
    output ssc_pkg::mem_req_t        mem_req,
    output ssc_pkg::emit_t           emit,
    input  logic                     emit_ready
);

    import ssc_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   sc_reg, sc_next;
    logic [CNT_W-1:0]   twi_reg, twi_next;
    logic [CNT_W-1:0]   tmi_reg, tmi_next;
    logic               too_long_reg, too_long_next;
    logic               last_reg, last_next;
    logic [SYM_W-1:0]   top_reg, top_next;
    logic               top_fwd_reg, top_fwd_next;
    logic [SYM_W-1:0]   tgt_reg, tgt_next;
    logic               tgt_fwd_reg, tgt_fwd_next;

    logic               full;
    logic               push;
    logic [SYM_W-1:0]   top_val;
    logic [SYM_W-1:0]   tgt_val;
    logic               match;
    logic               pop_more;
    logic [CNT_W-1:0]   sc_dec;
    logic [CNT_W-1:0]   sc_dec2;
    logic [CNT_W-1:0]   tmi_inc;
    verdict_t           verdict_val;

    // shared decode
    assign full     = (twi_reg >= CNT_W'(STACK_DEPTH)) || (sc_reg >= CNT_W'(STACK_DEPTH));
    assign push     = in_valid && !too_long_reg && !full;
    assign top_val  = top_fwd_reg ? top_reg : stack_rdata;
    assign tgt_val  = tgt_fwd_reg ? tgt_reg : target_rdata;
    assign match    = (top_val == tgt_val);
    assign sc_dec   = sc_reg - CNT_W'(1);
    assign sc_dec2  = sc_reg - CNT_W'(2);
    assign tmi_inc  = tmi_reg + CNT_W'(1);
    assign pop_more = match && (sc_dec != '0) && (tmi_inc != twi_reg);

    // verdict of the finished sequence
    always_comb
    begin
        priority if (too_long_reg)
        begin
            verdict_val = VERDICT_TOO_LONG;
        end
        else if (sc_reg == '0)
        begin
            verdict_val = VERDICT_YES;
        end
        else
        begin
            verdict_val = VERDICT_NO;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (push)
                    begin
                        state_next = ST_COMPARE;
                    end
                    else if (last_char)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COMPARE:
            begin
                priority if (pop_more)
                begin
                    state_next = ST_COMPARE;
                end
                else if (last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sc_next       = sc_reg;
        twi_next      = twi_reg;
        tmi_next      = tmi_reg;
        too_long_next = too_long_reg;
        last_next     = last_reg;
        top_next      = top_reg;
        top_fwd_next  = top_fwd_reg;
        tgt_next      = tgt_reg;
        tgt_fwd_next  = tgt_fwd_reg;
        mem_req       = '0;
        in_ready      = 1'b0;
        emit          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_char;
                    if (!too_long_reg && full)
                    begin
                        too_long_next = 1'b1;
                    end
                    if (push)
                    begin
                        // push source, buffer target, fetch next unmatched target
                        mem_req.stack_we     = 1'b1;
                        mem_req.stack_waddr  = sc_reg[ADDR_W-1:0];
                        mem_req.stack_wdata  = source_char;
                        mem_req.target_we    = 1'b1;
                        mem_req.target_waddr = twi_reg[ADDR_W-1:0];
                        mem_req.target_wdata = target_char;
                        mem_req.target_re    = 1'b1;
                        mem_req.target_raddr = tmi_reg[ADDR_W-1:0];
                        sc_next      = sc_reg + CNT_W'(1);
                        twi_next     = twi_reg + CNT_W'(1);
                        top_next     = source_char;
                        top_fwd_next = 1'b1;
                        tgt_next     = target_char;
                        tgt_fwd_next = (tmi_reg == twi_reg);
                    end
                end
            end
            ST_COMPARE:
            begin
                if (match)
                begin
                    sc_next  = sc_dec;
                    tmi_next = tmi_inc;
                end
                if (pop_more)
                begin
                    // fetch new top and next target for another compare
                    mem_req.stack_re     = 1'b1;
                    mem_req.stack_raddr  = sc_dec2[ADDR_W-1:0];
                    mem_req.target_re    = 1'b1;
                    mem_req.target_raddr = tmi_inc[ADDR_W-1:0];
                    top_fwd_next = 1'b0;
                    tgt_fwd_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                emit.valid   = 1'b1;
                emit.verdict = verdict_val;
                if (emit_ready)
                begin
                    sc_next       = '0;
                    twi_next      = '0;
                    tmi_next      = '0;
                    too_long_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sc_reg       <= '0;
            twi_reg      <= '0;
            tmi_reg      <= '0;
            too_long_reg <= 1'b0;
            last_reg     <= 1'b0;
            top_fwd_reg  <= 1'b0;
            tgt_fwd_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sc_reg       <= sc_next;
            twi_reg      <= twi_next;
            tmi_reg      <= tmi_next;
            too_long_reg <= too_long_next;
            last_reg     <= last_next;
            top_fwd_reg  <= top_fwd_next;
            tgt_fwd_reg  <= tgt_fwd_next;
        end
    end

    // forwarded symbols
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        tgt_reg <= tgt_next;
    end

endmodule
